// ===== rtl/core/ngh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngh_pkg: shared types and constants of the noise gate
// register indexes, fixed coefficients and the sequencer state type
// ----------------------------------------------------------------------------
package ngh_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEF    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES    = 2'd3;

  // register widths and reset values
  localparam int THR_W  = 23;
  localparam int COEF_W = 16;
  localparam int HOLD_W = 13;

  localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd29950;
  localparam logic [COEF_W-1:0] RELEASE_RST = 16'd399;

  // arithmetic constants
  localparam int ENV_W  = 24;
  localparam int GAIN_W = 17;
  localparam int Q14_W  = 15;
  localparam logic signed [16:0]       ENV_COEF = 17'sd1311;
  localparam logic [GAIN_W-1:0]        GAIN_ONE = 17'd65536;
  localparam logic [Q14_W-1:0]         Q14_ONE  = 15'd16384;
  localparam logic [ENV_W-1:0]         ENV_MAX  = 24'hFFFFFF;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_ENV_MUL  = 7'b0000010,
    ST_ENV_ADD  = 7'b0000100,
    ST_GAIN_MUL = 7'b0001000,
    ST_GAIN_ADD = 7'b0010000,
    ST_OUT_MUL  = 7'b0100000,
    ST_OUT_SAT  = 7'b1000000
  } state_t;

endpackage

// ===== rtl/core/ngh_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngh_in_if: input sample channel
// valid/ready handshake carrying one signed audio sample per word
// ----------------------------------------------------------------------------
interface ngh_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/core/ngh_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngh_out_if: gated sample channel
// valid/ready handshake carrying one signed gated sample per word
// ----------------------------------------------------------------------------
interface ngh_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/core/noise_gate_with_hold.sv =====
`timescale 1ns / 1ps
// one word is worked on at a time: a new word is taken only in the idle state;
// one shared multiplier is used three times per word (envelope, gain, output),
//   each use followed by an add/clamp step
// the result sits in an output register; a new word is taken while it waits
// reset (rst_n, synchronous, active low): envelope 0, gain unity, hold 0,
//   gate open, registers to threshold 0, attack 29950, release 399, hold 0
// ----------------------------------------------------------------------------
// noise_gate_with_hold: noise gate with hold, attack and release
// envelope follower, gate/hold logic and gain smoothing on a shared multiplier
// ----------------------------------------------------------------------------
module noise_gate_with_hold #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ngh_in_if.sink                          in_s,
  ngh_out_if.source                       out_s,
  input  logic                            cfg_we,
  input  logic [ngh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ngh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // multiplier operand widths: a is the wide signed operand, b the coefficient
  localparam int MA = (SAMPLE_BITS > 26) ? SAMPLE_BITS : 26;
  localparam int MB = 17;
  localparam int PW = MA + MB;
  // magnitude rescale to q23
  localparam int MAG_W = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
  localparam int LSH   = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
  localparam int RSH   = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
  // output saturation bounds
  localparam logic signed [PW-1:0] Y_MAX =
    {{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] Y_MIN = ~Y_MAX;

  // ---------------------------------------------------------------- config
  logic [ngh_pkg::THR_W-1:0]  thr_r;
  logic [ngh_pkg::COEF_W-1:0] attack_r;
  logic [ngh_pkg::COEF_W-1:0] release_r;
  logic [ngh_pkg::HOLD_W-1:0] hold_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= '0;
      attack_r   <= ngh_pkg::ATTACK_RST;
      release_r  <= ngh_pkg::RELEASE_RST;
      hold_cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ngh_pkg::CFG_THRESHOLD_LEVEL: thr_r      <= cfg_data[ngh_pkg::THR_W-1:0];
        ngh_pkg::CFG_ATTACK_COEF:     attack_r   <= cfg_data[ngh_pkg::COEF_W-1:0];
        ngh_pkg::CFG_RELEASE_COEF:    release_r  <= cfg_data[ngh_pkg::COEF_W-1:0];
        ngh_pkg::CFG_HOLD_SAMPLES:    hold_cfg_r <= cfg_data[ngh_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  ngh_pkg::state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0]  sample_r;      // word under work
  logic [ngh_pkg::ENV_W-1:0]      env_r;         // q23 envelope
  logic [ngh_pkg::GAIN_W-1:0]     gain_r;        // q16 gain, 0..65536
  logic [ngh_pkg::HOLD_W-1:0]     hold_left_r;
  logic                           gate_open_r;
  logic signed [PW-1:0]           prod_r;        // shared multiplier result
  logic signed [SAMPLE_BITS-1:0]  out_data_r;
  logic                           out_valid_r;

  logic in_fire;
  logic out_fire;
  logic out_load;

  assign in_s.ready = (state_r == ngh_pkg::ST_IDLE);
  assign in_fire    = in_s.valid && in_s.ready;
  assign out_fire   = out_valid_r && out_s.ready;
  // final stage waits while the previous result is still unclaimed
  assign out_load   = (state_r == ngh_pkg::ST_OUT_SAT) && (!out_valid_r || out_s.ready);

  assign out_s.valid      = out_valid_r;
  assign out_s.sample_out = out_data_r;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ngh_pkg::ST_IDLE:     if (in_fire) state_nxt = ngh_pkg::ST_ENV_MUL;
      ngh_pkg::ST_ENV_MUL:  state_nxt = ngh_pkg::ST_ENV_ADD;
      ngh_pkg::ST_ENV_ADD:  state_nxt = ngh_pkg::ST_GAIN_MUL;
      ngh_pkg::ST_GAIN_MUL: state_nxt = ngh_pkg::ST_GAIN_ADD;
      ngh_pkg::ST_GAIN_ADD: state_nxt = ngh_pkg::ST_OUT_MUL;
      ngh_pkg::ST_OUT_MUL:  state_nxt = ngh_pkg::ST_OUT_SAT;
      ngh_pkg::ST_OUT_SAT:  if (out_load) state_nxt = ngh_pkg::ST_IDLE;
      default:              state_nxt = ngh_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- magnitude
  // |sample| rescaled to q23; the most negative sample gives exactly 2^23
  logic [SAMPLE_BITS-1:0] abs_s;
  logic [MAG_W-1:0]       abs_ext;
  logic [MAG_W-1:0]       mag_w;
  logic [ngh_pkg::ENV_W-1:0] mag_q23;

  assign abs_s   = sample_r[SAMPLE_BITS-1] ? (~sample_r + 1'b1) : sample_r;
  assign abs_ext = MAG_W'(abs_s);
  assign mag_w   = (abs_ext << LSH) >> RSH;
  assign mag_q23 = mag_w[ngh_pkg::ENV_W-1:0];

  // ---------------------------------------------------------------- operands
  logic signed [25:0] env_diff;     // magnitude - envelope
  logic signed [17:0] gain_diff;    // target - gain
  logic [ngh_pkg::COEF_W-1:0] coef;
  logic [17:0] q14_rnd;
  logic [ngh_pkg::Q14_W-1:0] q14;
  logic signed [MA-1:0] op_a;
  logic signed [MB-1:0] op_b;

  assign env_diff  = $signed({2'b00, mag_q23}) - $signed({2'b00, env_r});
  assign gain_diff = gate_open_r ? $signed({1'b0, ngh_pkg::GAIN_ONE} - {1'b0, gain_r})
                                 : -$signed({1'b0, gain_r});
  assign coef      = gate_open_r ? attack_r : release_r;

  // q14 gain: round then limit to one
  assign q14_rnd = {1'b0, gain_r} + 18'd2;
  assign q14     = (q14_rnd[17:2] > 16'(ngh_pkg::Q14_ONE)) ? ngh_pkg::Q14_ONE
                                                           : q14_rnd[16:2];

  always_comb begin
    case (state_r)
      ngh_pkg::ST_ENV_MUL: begin
        op_a = MA'(env_diff);
        op_b = ngh_pkg::ENV_COEF;
      end
      ngh_pkg::ST_GAIN_MUL: begin
        op_a = MA'(gain_diff);
        op_b = $signed({1'b0, coef});
      end
      ngh_pkg::ST_OUT_MUL: begin
        op_a = MA'(sample_r);
        op_b = $signed({2'b00, q14});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- post-multiply
  logic signed [PW-1:0]  step16;    // floor(product / 2^16)
  logic signed [PW-1:0]  y_full;    // floor(product / 2^14)
  logic signed [26:0]    env_sum;
  logic [ngh_pkg::ENV_W-1:0] env_new;
  logic signed [18:0]    gain_sum;
  logic [ngh_pkg::GAIN_W-1:0] gain_new;
  logic                  gate_hit;

  assign step16 = prod_r >>> 16;
  assign y_full = prod_r >>> 14;

  assign env_sum = $signed({3'b000, env_r}) + 27'(step16);
  always_comb begin
    if (env_sum < 0)
      env_new = '0;
    else if (env_sum > $signed({3'b000, ngh_pkg::ENV_MAX}))
      env_new = ngh_pkg::ENV_MAX;
    else
      env_new = env_sum[ngh_pkg::ENV_W-1:0];
  end

  // zero threshold keeps the gate open
  assign gate_hit = (thr_r == '0) || (env_new > {1'b0, thr_r});

  assign gain_sum = $signed({2'b00, gain_r}) + 19'(step16);
  always_comb begin
    if (gain_sum < 0)
      gain_new = '0;
    else if (gain_sum > $signed({2'b00, ngh_pkg::GAIN_ONE}))
      gain_new = ngh_pkg::GAIN_ONE;
    else
      gain_new = gain_sum[ngh_pkg::GAIN_W-1:0];
  end

  // ---------------------------------------------------------------- datapath regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ngh_pkg::ST_IDLE;
      env_r       <= '0;
      gain_r      <= ngh_pkg::GAIN_ONE;
      hold_left_r <= '0;
      gate_open_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == ngh_pkg::ST_ENV_ADD) begin
        env_r <= env_new;
        if (gate_hit) begin
          gate_open_r <= 1'b1;
          hold_left_r <= hold_cfg_r;
        end else if (gate_open_r && hold_left_r != '0) begin
          hold_left_r <= hold_left_r - 1'b1;
        end else begin
          gate_open_r <= 1'b0;
        end
      end

      if (state_r == ngh_pkg::ST_GAIN_ADD)
        gain_r <= gain_new;

      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_fire)
        out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire)
      sample_r <= in_s.sample_in;
    // product held until its add or saturation step takes it, even under a stall
    if (state_r inside {ngh_pkg::ST_ENV_MUL, ngh_pkg::ST_GAIN_MUL, ngh_pkg::ST_OUT_MUL})
      prod_r <= PW'(op_a * op_b);
    if (out_load) begin
      if (y_full > Y_MAX)
        out_data_r <= Y_MAX[SAMPLE_BITS-1:0];
      else if (y_full < Y_MIN)
        out_data_r <= Y_MIN[SAMPLE_BITS-1:0];
      else
        out_data_r <= y_full[SAMPLE_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- checks
  // gain never leaves 0..unity
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= ngh_pkg::GAIN_ONE)
    else $error("gain above unity");

  // a pending hold count only exists while the gate is open
  a_hold_open: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_left_r != '0) |-> gate_open_r)
    else $error("hold count with closed gate");

  // a new result word only comes out of the saturation step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ngh_pkg::ST_OUT_SAT))
    else $error("result word raised outside final step");

endmodule

// ===== verif/noise_gate_with_hold_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_gate_with_hold_test: self-checking bench for the noise gate
// drives sample words in random bursts, stalls the gated output on a shifting
// pattern, and checks every gated word against a fixed-point gate predictor
// ----------------------------------------------------------------------------
module noise_gate_with_hold_test;

  localparam int SAMPLE_BITS = 24;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ngh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ngh_pkg::CFG_DATA_W-1:0] cfg_data;

  ngh_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  ngh_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  noise_gate_with_hold #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_ch),
    .out_s    (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // samples waiting to be sent, gated words still owed by the block
  logic signed [SAMPLE_BITS-1:0] pending_samples[$];
  logic signed [SAMPLE_BITS-1:0] expected_gated[$];
  logic signed [SAMPLE_BITS-1:0] expected_word;
  int mismatch_count = 0;

  // mirror of the gate registers
  logic [ngh_pkg::THR_W-1:0]  thr_level;
  logic [ngh_pkg::COEF_W-1:0] atk_coef;
  logic [ngh_pkg::COEF_W-1:0] rel_coef;
  logic [ngh_pkg::HOLD_W-1:0] hold_len;

  // mirror of the gate state
  logic [ngh_pkg::ENV_W-1:0]  env_level;
  logic [ngh_pkg::GAIN_W-1:0] gain_q16;
  logic [ngh_pkg::HOLD_W-1:0] hold_count;
  logic                       gate_is_open;

  // one sample through envelope, gate/hold, gain smoothing and the output multiply
  function automatic logic signed [SAMPLE_BITS-1:0] gate_sample(
    input logic signed [SAMPLE_BITS-1:0] smp
  );
    longint s, mag, env, g, coef, target, q14, y;
    s   = smp;
    mag = (s < 0) ? -s : s;

    // one-pole envelope, arithmetic shift gives the floor
    env = env_level;
    env = env + ((longint'(ngh_pkg::ENV_COEF) * (mag - env)) >>> 16);
    if (env < 0) env = 0;
    if (env > longint'(ngh_pkg::ENV_MAX)) env = ngh_pkg::ENV_MAX;
    env_level = env[ngh_pkg::ENV_W-1:0];

    // zero threshold keeps the gate open; hold counts down before closing
    if (thr_level == '0 || env_level > thr_level) begin
      gate_is_open = 1'b1;
      hold_count   = hold_len;
    end else if (gate_is_open && hold_count != '0) begin
      hold_count = hold_count - 1'b1;
    end else begin
      gate_is_open = 1'b0;
    end

    // gain glides toward unity while open, toward zero while closed
    coef   = gate_is_open ? atk_coef : rel_coef;
    target = gate_is_open ? longint'(ngh_pkg::GAIN_ONE) : 0;
    g = gain_q16;
    g = g + ((coef * (target - g)) >>> 16);
    if (g < 0) g = 0;
    if (g > longint'(ngh_pkg::GAIN_ONE)) g = ngh_pkg::GAIN_ONE;
    gain_q16 = g[ngh_pkg::GAIN_W-1:0];

    q14 = (g + 2) >>> 2;
    if (q14 > longint'(ngh_pkg::Q14_ONE)) q14 = ngh_pkg::Q14_ONE;

    y = (s * q14) >>> 14;
    if (y > longint'(SAMPLE_MAX)) y = SAMPLE_MAX;
    if (y < longint'(SAMPLE_MIN)) y = SAMPLE_MIN;
    return y[SAMPLE_BITS-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // accepted word: predict its gated value now
      if (in_ch.valid && in_ch.ready)
        expected_gated.push_back(gate_sample(in_ch.sample_in));

      // a new word may go out once the old one is taken
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.sample_in <= pending_samples.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            // about a quarter of the bursts run straight on
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready follows a 16-bit pattern, reshuffled every period
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  stall_phase = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_gated.size() == 0) begin
          $display("%t: unexpected gated word, expected none, actual %0d",
                   $realtime, out_ch.sample_out);
          mismatch_count++;
        end else begin
          expected_word = expected_gated.pop_front();
          if (out_ch.sample_out !== expected_word) begin
            $display("%t: sample_out mismatch, expected %0d, actual %0d",
                     $realtime, expected_word, out_ch.sample_out);
            mismatch_count++;
          end
        end
      end

      stall_phase <= stall_phase + 1'b1;
      out_ch.ready <= stall_pattern[stall_phase];
      if (stall_phase == 4'hF) begin
        case ($urandom_range(0, 3))
          0: stall_pattern <= 16'hFFFF;                    // no stalls
          1: stall_pattern <= 16'($urandom);               // even mix
          2: stall_pattern <= 16'($urandom) & 16'($urandom); // mostly stalled
          default: stall_pattern <= 16'($urandom) | 16'($urandom);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // settles at a falling edge once nothing is in flight
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_ch.valid || expected_gated.size() != 0);
  endtask

  // writes all four registers on back-to-back edges, block must be idle
  task automatic apply_settings(input logic [ngh_pkg::THR_W-1:0] thr,
                                input logic [ngh_pkg::COEF_W-1:0] atk,
                                input logic [ngh_pkg::COEF_W-1:0] rel,
                                input logic [ngh_pkg::HOLD_W-1:0] hold);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ngh_pkg::CFG_THRESHOLD_LEVEL;
    cfg_data <= ngh_pkg::CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_index <= ngh_pkg::CFG_ATTACK_COEF;
    cfg_data <= ngh_pkg::CFG_DATA_W'(atk);
    @(posedge clk);
    cfg_index <= ngh_pkg::CFG_RELEASE_COEF;
    cfg_data <= ngh_pkg::CFG_DATA_W'(rel);
    @(posedge clk);
    cfg_index <= ngh_pkg::CFG_HOLD_SAMPLES;
    cfg_data <= ngh_pkg::CFG_DATA_W'(hold);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_level = thr;
    atk_coef  = atk;
    rel_coef  = rel;
    hold_len  = hold;
    // queue pushes stay off the rising edge
    @(negedge clk);
  endtask

  // random-signed sample of magnitude up to amp; at full-scale amp, rarely the most negative code
  function automatic logic signed [SAMPLE_BITS-1:0] tone_sample(input int amp);
    int m;
    m = $urandom_range(0, amp);
    if (amp == int'(SAMPLE_MAX) && $urandom_range(0, 31) == 0)
      return SAMPLE_MIN;
    return $urandom_range(0, 1) ? SAMPLE_BITS'(-m) : SAMPLE_BITS'(m);
  endfunction

  // loud passages followed by quiet tails, so the gate opens, holds and closes;
  // a few stretches of raw noise in between; exactly count words in all
  task automatic push_passages(input int count);
    int sent, len, amp;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 10);
        if (len > count - sent) len = count - sent;
        repeat (len) pending_samples.push_back(SAMPLE_BITS'($urandom));
        sent += len;
      end else begin
        len = $urandom_range(10, 60);
        if (len > count - sent) len = count - sent;
        amp = $urandom_range(1 << 18, int'(SAMPLE_MAX));
        repeat (len) pending_samples.push_back(tone_sample(amp));
        sent += len;
        len = $urandom_range(10, 80);
        if (len > count - sent) len = count - sent;
        amp = $urandom_range(0, 4096);
        repeat (len) pending_samples.push_back(tone_sample(amp));
        sent += len;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready = 1'b0;

    // predictor starts from the reset state
    thr_level    = '0;
    atk_coef     = ngh_pkg::ATTACK_RST;
    rel_coef     = ngh_pkg::RELEASE_RST;
    hold_len     = '0;
    env_level    = '0;
    gain_q16     = ngh_pkg::GAIN_ONE;
    hold_count   = '0;
    gate_is_open = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, gate always open: field extremes and bit patterns
    pending_samples.push_back(24'sd0);
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back(-24'sd1);
    pending_samples.push_back(24'sd1);
    pending_samples.push_back(24'sh555555);
    pending_samples.push_back(24'shAAAAAA);
    pending_samples.push_back(SAMPLE_MAX);
    wait_drained();

    // loud words, then quiet words, with a hold of three words; the slow envelope
    // stays above the threshold throughout, so the gate stays open
    apply_settings(23'd600000, 16'd65535, 16'd65535, 13'd3);
    repeat (2) begin
      pending_samples.push_back(SAMPLE_MAX);
      pending_samples.push_back(SAMPLE_MIN);
    end
    repeat (6) begin
      pending_samples.push_back(24'sd2000);
      pending_samples.push_back(-24'sd2000);
    end
    wait_drained();

    // random passages under a spread of settings, extremes included
    apply_settings(23'd5872025, 16'd65535, 16'd65535, 13'd0);
    push_passages(80);
    wait_drained();

    apply_settings(ngh_pkg::THR_W'($urandom_range(1000, 2000000)), 16'd0, 16'd0,
                   ngh_pkg::HOLD_W'($urandom_range(0, 30)));
    push_passages(80);
    wait_drained();

    apply_settings(ngh_pkg::THR_W'($urandom_range(1000, 2000000)),
                   ngh_pkg::COEF_W'($urandom), ngh_pkg::COEF_W'($urandom),
                   ngh_pkg::HOLD_W'($urandom_range(0, 30)));
    push_passages(80);
    wait_drained();

    // threshold above any envelope, hold of 4915 words
    apply_settings(23'h7FFFFF, ngh_pkg::COEF_W'($urandom), ngh_pkg::COEF_W'($urandom),
                   13'd4915);
    push_passages(64);
    wait_drained();

    // smallest nonzero threshold, widest hold field
    apply_settings(23'd1, ngh_pkg::COEF_W'($urandom), ngh_pkg::COEF_W'($urandom),
                   13'h1FFF);
    push_passages(48);
    wait_drained();

    apply_settings(ngh_pkg::THR_W'($urandom_range(1000, 2000000)), 16'd1, 16'd1, 13'd1);
    push_passages(80);
    wait_drained();

    // gating disabled again, random smoothing
    apply_settings(23'd0, ngh_pkg::COEF_W'($urandom), ngh_pkg::COEF_W'($urandom),
                   ngh_pkg::HOLD_W'($urandom_range(0, 30)));
    push_passages(64);
    wait_drained();

    apply_settings(ngh_pkg::THR_W'($urandom_range(1000, 2000000)),
                   ngh_pkg::COEF_W'($urandom), ngh_pkg::COEF_W'($urandom),
                   ngh_pkg::HOLD_W'($urandom_range(0, 30)));
    push_passages(80);
    wait_drained();

    // let any late word show up before the verdict
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== noise_gate_with_hold.f =====
rtl/core/ngh_pkg.sv
rtl/core/ngh_in_if.sv
rtl/core/ngh_out_if.sv
rtl/core/noise_gate_with_hold.sv
verif/noise_gate_with_hold_test.sv
